// ----- rtl/core/hrrn_ready_queue_scheduler_macros.svh -----
// Assertion macros used by the scheduler checker.
`ifndef HRRN_READY_QUEUE_SCHEDULER_MACROS_SVH
`define HRRN_READY_QUEUE_SCHEDULER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define HRRN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define HRRN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/hrrn_pkg.sv -----
`default_nettype none
package hrrn_pkg;
  localparam logic [1:0] CMD_ADMIT    = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_DISPATCHED = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_INIT  = 2'd1;
  localparam logic [1:0] REG_FIFO  = 2'd2;

  localparam logic [8:0]  ALPHA_RESET = 9'd128;
  localparam logic [15:0] INIT_RESET  = 16'd10000;
  localparam logic [8:0]  ALPHA_ONE   = 9'd256;

  // One ready-queue entry as held in memory
  typedef struct packed {
    logic [15:0] pid;
    logic [31:0] arrival;
    logic [15:0] estimate;
    logic [31:0] seq;
  } entry_t;
endpackage
`default_nettype wire

// ----- rtl/core/hrrn_ready_queue_scheduler.sv -----
`default_nettype none
// Ready-queue scheduler, highest response ratio next. One command per input
// transfer (admit, dispatch, tick), one result transfer per command. Entries
// live in a single-port memory of DEPTH rows with a registered read; a
// row of valid flops gives the free slot and the empty check. Tick and the
// unused command go from idle straight to output, as does dispatch from an
// empty queue; admit passes through estimate, multiply, write and output
// (no write when the queue is full). Dispatch reads each row in turn, and in
// ratio mode runs a two-step cross-multiply compare for each valid row after
// the first. The 33x16 multiplier bounds the step. A stalled result adds its
// wait. The output register frees the input side while a result waits.
module hrrn_ready_queue_scheduler #(
  parameter int DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [1:0] command, [17:2] pid, [18] has_run, [34:19] last_burst,
  // [50:35] prev_estimate, [55:51] zero
  input  wire  [55:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [1:0] status, [17:2] out_pid, [33:18] out_estimate, [65:34] out_wait,
  // [71:66] zero
  output logic [71:0] out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ESTIM, S_READ, S_MUL, S_CMP, S_WRITE, S_OUT
  } state_t;

  // Configuration registers
  logic [8:0]  alpha_r;
  logic [15:0] init_r;
  logic        fifo_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= hrrn_pkg::ALPHA_RESET;
      init_r  <= hrrn_pkg::INIT_RESET;
      fifo_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hrrn_pkg::REG_ALPHA: alpha_r <= cfg_pwdata[8:0];
        hrrn_pkg::REG_INIT:  init_r  <= cfg_pwdata[15:0];
        hrrn_pkg::REG_FIFO:  fifo_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[1:0] == 2'b00) begin
      case (cfg_idx)
        hrrn_pkg::REG_ALPHA: cfg_prdata = {23'd0, alpha_r};
        hrrn_pkg::REG_INIT:  cfg_prdata = {16'd0, init_r};
        hrrn_pkg::REG_FIFO:  cfg_prdata = {31'd0, fifo_r};
        default:             cfg_prdata = 32'd0;
      endcase
    end
  end

  // Entry memory, synchronous read
  hrrn_pkg::entry_t mem [DEPTH];
  hrrn_pkg::entry_t rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  hrrn_pkg::entry_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_q <= mem[mem_addr];
  end

  // Control and datapath registers
  state_t        state_r;
  logic [DEPTH-1:0] valid_r;
  logic [31:0]   now_r, nseq_r;
  logic [1:0]    cmd_r;
  logic [1:0]    st_r;
  logic [15:0]   pid_r, last_r, prev_r;
  logic          hrun_r;
  logic [CW-1:0] scan_r;     // next row to read
  logic [AW-1:0] cur_r;      // row whose data sits in rd_q
  logic          cur_v_r;
  logic          found_r;
  logic [AW-1:0] best_idx_r;
  hrrn_pkg::entry_t best_r, cand_r;
  logic [47:0]   lhs_r, rhs_r;
  logic [24:0]   prod_a_r, prod_b_r;
  logic [15:0]   est_r;
  logic          out_v_r;
  logic [71:0]   out_d_r;

  // Lowest free slot and fill flag
  logic [AW-1:0] free_idx;
  logic          full;
  always_comb begin
    free_idx = '0;
    full = 1'b1;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        free_idx = AW'(k);
        full = 1'b0;
      end
    end
  end

  // Ratio compare terms for the candidate against the best so far
  logic [31:0] w_c, w_b;
  logic [32:0] sum_c, sum_b;
  logic [48:0] mul_l, mul_r;
  logic [31:0] age_c, age_b;
  logic        cand_older;
  assign w_c = now_r - cand_r.arrival;
  assign w_b = now_r - best_r.arrival;
  assign sum_c = {1'b0, w_c} + {17'd0, cand_r.estimate};
  assign sum_b = {1'b0, w_b} + {17'd0, best_r.estimate};
  assign mul_l = sum_c * best_r.estimate;
  assign mul_r = sum_b * cand_r.estimate;
  assign age_c = nseq_r - cand_r.seq;
  assign age_b = nseq_r - best_r.seq;
  assign cand_older = age_c > age_b;

  // Estimate: a*last and (256-a)*prev, registered before the add
  logic [8:0] alpha_sat;
  assign alpha_sat = (alpha_r > hrrn_pkg::ALPHA_ONE) ? hrrn_pkg::ALPHA_ONE : alpha_r;
  logic [25:0] est_sum;
  assign est_sum = {1'b0, prod_a_r} + {1'b0, prod_b_r} + 26'd128;
  logic [15:0] est_raw;
  assign est_raw = hrun_r ? est_sum[23:8] : init_r;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_addr = scan_r[AW-1:0];
    mem_wd.pid = pid_r;
    mem_wd.arrival = now_r;
    mem_wd.estimate = est_r;
    mem_wd.seq = nseq_r;
    if (state_r == S_WRITE) begin
      mem_we = 1'b1;
      mem_addr = free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      now_r <= '0;
      nseq_r <= '0;
      out_v_r <= 1'b0;
      found_r <= 1'b0;
      cur_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_tready && state_r != S_OUT) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r <= in_tdata[1:0];
            pid_r <= in_tdata[17:2];
            hrun_r <= in_tdata[18];
            last_r <= in_tdata[34:19];
            prev_r <= in_tdata[50:35];
            scan_r <= '0;
            found_r <= 1'b0;
            cur_v_r <= 1'b0;
            st_r <= (in_tdata[1:0] == hrrn_pkg::CMD_DISPATCH && valid_r == '0) ?
                    hrrn_pkg::ST_EMPTY : hrrn_pkg::ST_DONE;
            case (in_tdata[1:0])
              hrrn_pkg::CMD_ADMIT: state_r <= S_ESTIM;
              hrrn_pkg::CMD_DISPATCH: state_r <= (valid_r == '0) ? S_OUT : S_READ;
              hrrn_pkg::CMD_TICK: begin
                now_r <= now_r + 32'd1;
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_ESTIM: begin
          prod_a_r <= 25'(alpha_sat * last_r);
          prod_b_r <= 25'((hrrn_pkg::ALPHA_ONE - alpha_sat) * prev_r);
          state_r <= S_MUL;
        end
        S_READ: begin
          // Row scan_r is presented this cycle; data lands in rd_q next
          cur_r <= scan_r[AW-1:0];
          cur_v_r <= valid_r[scan_r[AW-1:0]];
          scan_r <= scan_r + CW'(1);
          state_r <= S_CMP;
        end
        S_CMP: begin
          // Take in the row that was read
          if (cur_v_r) begin
            if (!found_r) begin
              best_r <= rd_q;
              best_idx_r <= cur_r;
              found_r <= 1'b1;
              state_r <= (scan_r == CW'(DEPTH)) ? S_OUT : S_READ;
            end else if (fifo_r) begin
              if ((nseq_r - rd_q.seq) > age_b) begin
                best_r <= rd_q;
                best_idx_r <= cur_r;
              end
              state_r <= (scan_r == CW'(DEPTH)) ? S_OUT : S_READ;
            end else begin
              cand_r <= rd_q;
              state_r <= S_MUL;
            end
          end else begin
            state_r <= (scan_r == CW'(DEPTH)) ? S_OUT : S_READ;
          end
          cur_v_r <= 1'b0;
        end
        S_MUL: begin
          if (cmd_r == hrrn_pkg::CMD_ADMIT) begin
            if (full) begin
              st_r <= hrrn_pkg::ST_FULL;
              state_r <= S_OUT;
            end else begin
              est_r <= (est_raw == 16'd0) ? 16'd1 : est_raw;
              state_r <= S_WRITE;
            end
          end else if (!cur_v_r) begin
            // First phase: register both products
            lhs_r <= mul_l[47:0];
            rhs_r <= mul_r[47:0];
            cur_v_r <= 1'b1;
          end else begin
            if (lhs_r > rhs_r || (lhs_r == rhs_r && cand_older)) begin
              best_r <= cand_r;
              best_idx_r <= cur_r;
            end
            cur_v_r <= 1'b0;
            state_r <= (scan_r == CW'(DEPTH)) ? S_OUT : S_READ;
          end
        end
        S_WRITE: begin
          valid_r[free_idx] <= 1'b1;
          nseq_r <= nseq_r + 32'd1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_v_r || out_tready) begin
            if (cmd_r == hrrn_pkg::CMD_DISPATCH && found_r) begin
              valid_r[best_idx_r] <= 1'b0;
              out_d_r <= {6'd0, now_r - best_r.arrival, best_r.estimate, best_r.pid,
                          hrrn_pkg::ST_DISPATCHED};
            end else begin
              out_d_r <= {70'd0, st_r};
            end
            out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/hrrn_ready_queue_scheduler_chk.sv -----
`default_nettype none
`include "hrrn_ready_queue_scheduler_macros.svh"
// Port-level checker for the scheduler
module hrrn_ready_queue_scheduler_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [71:0] out_tdata
);
  // A stalled result holds its value
  `HRRN_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  // Input is not taken in the cycle after a transfer
  `HRRN_ASSERT_NXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken twice in a row")
  // Fields are zero unless dispatched
  `HRRN_ASSERT_IMP(a_zero, clk, rst_n, out_tvalid && out_tdata[1:0] != hrrn_pkg::ST_DISPATCHED, out_tdata[65:2] == 64'd0, "payload not cleared")
  // Dispatched estimate is never zero
  `HRRN_ASSERT_IMP(a_est, clk, rst_n, out_tvalid && out_tdata[1:0] == hrrn_pkg::ST_DISPATCHED, out_tdata[33:18] != 16'd0, "zero estimate")
endmodule

bind hrrn_ready_queue_scheduler hrrn_ready_queue_scheduler_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire
